// File: rtl/pyst_pkg.sv
// Shared types, constants and the wrap helper for the palette yaw snap / tilt clamp block.
// Angles are Q3.12 radians; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pyst_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int PALETTE_MAX_DEF = 64;

    // pi in Q32, rounded to nearest at ANGLE_FRAC_BITS fraction bits
    localparam longint PI_Q32  = 64'd13493037705;
    localparam longint PI_FX_L =
        (PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);

    localparam logic [13:0] PI_FX     = 14'(PI_FX_L);
    localparam logic [14:0] TWO_PI_FX = 15'(2 * PI_FX_L);

    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    localparam logic [2:0] REG_PALETTE_COUNT = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP    = 3'd1;
    localparam logic [2:0] REG_TILT_X        = 3'd2;
    localparam logic [2:0] REG_TILT_Y        = 3'd3;
    localparam logic [2:0] REG_TILT_Z        = 3'd4;

    localparam logic [6:0] EMPTY_INDEX = 7'h7F;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic [14:0]        wrap_x;
        logic [14:0]        wrap_y;
        logic [14:0]        wrap_z;
        logic [14:0]        yaw;
        logic [13:0]        best_dist;
        logic [14:0]        best_yaw;
        logic [IDX_W-1:0]   best_idx;
    } cell_word_t;

    // reduce any 16-bit angle into [0, 2pi)
    function automatic logic [14:0] wrap_angle(input logic signed [15:0] a);
        logic signed [16:0] e;
        logic signed [16:0] tp;
        logic signed [16:0] r;
        e  = 17'(a);
        tp = $signed({2'b00, TWO_PI_FX});
        if (e < -tp) begin
            r = e + tp + tp;
        end else if (e < 17'sd0) begin
            r = e + tp;
        end else if (e >= tp) begin
            r = e - tp;
        end else begin
            r = e;
        end
        return r[14:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/palette_yaw_snap_tilt_clamp.sv
// Palette yaw snap and circular tilt clamp for one Euler angle triple.
// Pipeline: wrap stage, one compare cell per palette entry, clamp window
// stage, output register. Throughput one word per cycle, set by the cell chain,
// which all advances together and holds on output stall.
// Reset (synchronous, aresetn low) clears all valid bits and returns the
// configuration to count 0, step 2pi, tilts 0. Depends on pyst_pkg, pyst_cell, pyst_clamp.
`timescale 1ns / 1ps
`default_nettype none

module palette_yaw_snap_tilt_clamp
    import pyst_pkg::*;
#(
    parameter int PALETTE_MAX = PALETTE_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // angle_x, angle_y, angle_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // clamped_x, clamped_y, clamped_z, chosen_index, pad
);

    logic [6:0]         count_reg;
    logic [14:0]        step_reg;
    logic [13:0]        tilt_x_reg;
    logic [13:0]        tilt_y_reg;
    logic [13:0]        tilt_z_reg;

    logic [COUNT_W-1:0] count_sat;
    logic [14:0]        step_mod;
    logic [13:0]        sat_x;
    logic [13:0]        sat_y;
    logic [13:0]        sat_z;
    logic               adv;

    cell_word_t         front_next;
    cell_word_t         chain_word [PALETTE_MAX+1];
    logic               chain_valid [PALETTE_MAX+1];
    logic               front_valid_reg;
    cell_word_t         front_word_reg;

    logic               a_valid_reg;
    logic signed [15:0] a_raw_x_reg;
    logic signed [15:0] a_raw_y_reg;
    logic signed [15:0] a_raw_z_reg;
    logic [6:0]         a_idx_reg;

    logic signed [16:0] res_x;
    logic signed [16:0] res_y;
    logic signed [16:0] res_z;
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic [63:0]        out_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 7'd0;
            step_reg   <= TWO_PI_FX;
            tilt_x_reg <= 14'd0;
            tilt_y_reg <= 14'd0;
            tilt_z_reg <= 14'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PALETTE_COUNT: count_reg  <= cfg_wdata[6:0];
                REG_ANGLE_STEP:    step_reg   <= cfg_wdata;
                REG_TILT_X:        tilt_x_reg <= cfg_wdata[13:0];
                REG_TILT_Y:        tilt_y_reg <= cfg_wdata[13:0];
                REG_TILT_Z:        tilt_z_reg <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        count_sat = (COUNT_W'(count_reg) > COUNT_W'(PALETTE_MAX)) ?
                    COUNT_W'(PALETTE_MAX) : COUNT_W'(count_reg);
        step_mod  = (step_reg >= TWO_PI_FX) ? 15'(step_reg - TWO_PI_FX) : step_reg;
        sat_x     = (tilt_x_reg > PI_FX) ? PI_FX : tilt_x_reg;
        sat_y     = (tilt_y_reg > PI_FX) ? PI_FX : tilt_y_reg;
        sat_z     = (tilt_z_reg > PI_FX) ? PI_FX : tilt_z_reg;
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        front_next           = '0;
        front_next.raw_x     = $signed(s_tdata[15:0]);
        front_next.raw_y     = $signed(s_tdata[31:16]);
        front_next.raw_z     = $signed(s_tdata[47:32]);
        front_next.wrap_x    = wrap_angle($signed(s_tdata[15:0]));
        front_next.wrap_y    = wrap_angle($signed(s_tdata[31:16]));
        front_next.wrap_z    = wrap_angle($signed(s_tdata[47:32]));
        front_next.best_dist = PI_FX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (adv) begin
            front_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            front_word_reg <= front_next;
        end
    end

    assign chain_word[0]  = front_word_reg;
    assign chain_valid[0] = front_valid_reg;

    for (genvar g = 0; g < PALETTE_MAX; g++) begin : g_cell
        pyst_cell #(
            .IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (chain_valid[g]),
            .in_word   (chain_word[g]),
            .step_mod  (step_mod),
            .count_sat (count_sat),
            .out_valid (chain_valid[g+1]),
            .out_word  (chain_word[g+1])
        );
    end

    pyst_clamp u_clamp_x (
        .aclk   (aclk),
        .en     (adv),
        .angle  (chain_word[PALETTE_MAX].wrap_x),
        .center (15'd0),
        .tilt   (sat_x),
        .res    (res_x)
    );

    pyst_clamp u_clamp_y (
        .aclk   (aclk),
        .en     (adv),
        .angle  (chain_word[PALETTE_MAX].wrap_y),
        .center (chain_word[PALETTE_MAX].best_yaw),
        .tilt   (sat_y),
        .res    (res_y)
    );

    pyst_clamp u_clamp_z (
        .aclk   (aclk),
        .en     (adv),
        .angle  (chain_word[PALETTE_MAX].wrap_z),
        .center (15'd0),
        .tilt   (sat_z),
        .res    (res_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= chain_valid[PALETTE_MAX];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_raw_x_reg <= chain_word[PALETTE_MAX].raw_x;
            a_raw_y_reg <= chain_word[PALETTE_MAX].raw_y;
            a_raw_z_reg <= chain_word[PALETTE_MAX].raw_z;
            a_idx_reg   <= chain_word[PALETTE_MAX].best_idx[6:0];
        end
    end

    // empty palette passes the raw angles through
    always_comb begin
        out_data_next = '0;
        if (count_sat == '0) begin
            out_data_next[16:0]  = 17'(a_raw_x_reg);
            out_data_next[33:17] = 17'(a_raw_y_reg);
            out_data_next[50:34] = 17'(a_raw_z_reg);
            out_data_next[57:51] = EMPTY_INDEX;
        end else begin
            out_data_next[16:0]  = res_x;
            out_data_next[33:17] = res_y;
            out_data_next[50:34] = res_z;
            out_data_next[57:51] = a_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/pyst_cell.sv
// One palette compare cell: checks entry IDX's distance to angle_y against the running best
// distance and hands the word plus the next entry's yaw to its neighbor. Uses pyst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pyst_cell
    import pyst_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire cell_word_t         in_word,
    input  wire logic [14:0]        step_mod,
    input  wire logic [COUNT_W-1:0] count_sat,
    output logic                    out_valid,
    output cell_word_t              out_word
);

    logic              valid_reg;
    cell_word_t        word_reg;
    cell_word_t        word_next;
    logic signed [15:0] diff;
    logic [14:0]       mag;
    logic [13:0]       gap;
    logic              take;
    logic [15:0]       yaw_sum;

    always_comb begin
        diff = $signed({1'b0, in_word.wrap_y}) - $signed({1'b0, in_word.yaw});
        mag  = (diff < 16'sd0) ? 15'(-diff) : diff[14:0];
        gap  = (mag > {1'b0, PI_FX}) ? 14'(TWO_PI_FX - mag) : mag[13:0];
        take = (IDX == 0) ||
               ((COUNT_W'(IDX) < count_sat) && (gap < in_word.best_dist));
        yaw_sum = {1'b0, in_word.yaw} + {1'b0, step_mod};

        word_next = in_word;
        if (take) begin
            word_next.best_dist = gap;
            word_next.best_yaw  = in_word.yaw;
            word_next.best_idx  = IDX_W'(IDX);
        end
        word_next.yaw = (yaw_sum >= {1'b0, TWO_PI_FX}) ?
                        15'(yaw_sum - {1'b0, TWO_PI_FX}) : yaw_sum[14:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// File: rtl/pyst_clamp.sv
// Circular clamp of a wrapped angle to center +/- tilt: the
// registered window and recentered angle, then the combinational select. Uses pyst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pyst_clamp
    import pyst_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [14:0]        angle,
    input  wire logic [14:0]        center,
    input  wire logic [13:0]        tilt,
    output logic signed [16:0]      res
);

    logic signed [17:0] two_pi;
    logic signed [17:0] pi_s;
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [17:0] v;
    logic signed [17:0] v_adj;
    logic signed [17:0] v_reg;
    logic signed [17:0] lo_reg;
    logic signed [17:0] hi_reg;
    logic signed [17:0] sel;
    logic               in_window;

    assign two_pi = $signed({3'b000, TWO_PI_FX});
    assign pi_s   = $signed({4'b0000, PI_FX});

    always_comb begin
        lo = $signed({3'b000, center}) - $signed({4'b0000, tilt});
        hi = $signed({3'b000, center}) + $signed({4'b0000, tilt});
        v  = $signed({3'b000, angle});
        if (v < lo - pi_s) begin
            v_adj = v + two_pi;
        end else if (v >= lo + pi_s) begin
            v_adj = v - two_pi;
        end else begin
            v_adj = v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg  <= v_adj;
            lo_reg <= lo;
            hi_reg <= hi;
        end
    end

    always_comb begin
        in_window = ((v_reg >= lo_reg) && (v_reg <= hi_reg)) ||
                    ((v_reg < lo_reg) && (v_reg + two_pi <= hi_reg));
        if (in_window) begin
            sel = v_reg;
        end else if (v_reg > lo_reg) begin
            sel = hi_reg;
        end else if (lo_reg - v_reg <= lo_reg + two_pi - hi_reg) begin
            sel = lo_reg;
        end else begin
            sel = hi_reg;
        end
        res = sel[16:0];
    end

endmodule

`default_nettype wire
